### hdl/tachometer_adaptive_iir_unit_macros.svh
// ----------------------------------------------------------------------------
// Tachometer assertion macros
// Shared concurrent assertion helpers for the tachometer block.
// ----------------------------------------------------------------------------
`ifndef TACHOMETER_ADAPTIVE_IIR_UNIT_MACROS_SVH
`define TACHOMETER_ADAPTIVE_IIR_UNIT_MACROS_SVH

// same-cycle implication
`define TAI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tachometer package
// Types, constants and the gain table shared by the tachometer modules.
// ----------------------------------------------------------------------------
package tai_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_W         = 2;
    localparam int COUNTER_BITS = 16;
    localparam int GAIN_ENTRIES = 32;
    localparam int IDX_W        = 5;
    localparam int GAIN_W       = 13;
    localparam int GAIN_SHIFT   = 12;
    localparam int NUM_W        = 26;
    localparam int DEN_W        = 32;
    localparam int SPEED_W      = 27;
    localparam int PROD_W       = 46;
    localparam int CNT_W        = 4;

    localparam logic [GAIN_W-1:0] FULL_GAIN = 13'd4096;

    // config register indexes
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SCALE   = 2'd1;
    localparam logic [1:0] REG_RISE    = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_LUT [0:GAIN_ENTRIES-1] = '{
        13'd4096, 13'd3891, 13'd3180, 13'd2587, 13'd2159, 13'd1846, 13'd1610, 13'd1426,
        13'd1279, 13'd1160, 13'd1060, 13'd977,  13'd905,  13'd843,  13'd789,  13'd742,
        13'd699,  13'd662,  13'd628,  13'd597,  13'd570,  13'd545,  13'd521,  13'd500,
        13'd481,  13'd463,  13'd446,  13'd430,  13'd416,  13'd402,  13'd389,  13'd377
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD,
        ST_SPD_WAIT,
        ST_CAP,
        ST_MUL,
        ST_FILT,
        ST_IDX_WAIT,
        ST_TIMEOUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

### hdl/tai_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tai_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tai_pkg::div_req_t         req,
    output logic                      busy,
    output logic                      done,
    output logic [tai_pkg::NUM_W-1:0] quot
);

    logic [tai_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [tai_pkg::DEN_W-1:0] den_reg;
    logic [tai_pkg::NUM_W-1:0] num_reg;
    logic [tai_pkg::NUM_W-1:0] quot_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [tai_pkg::DEN_W:0]   trial;
    logic                      fits;

    // shift in next numerator bit, subtract if it fits
    assign trial    = {rem_reg, num_reg[tai_pkg::NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? tai_pkg::DEN_W'(trial - {1'b0, den_reg})
                           : trial[tai_pkg::DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(tai_pkg::NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= '0;
            den_reg  <= req.den;
            num_reg  <= req.num;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[tai_pkg::NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[tai_pkg::NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### hdl/tachometer_adaptive_iir_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-channel fan tachometer with adaptive IIR smoothing
// Turns capture stamps and timer overflow ticks into per-channel speeds.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  s_        in    s_tvalid/s_tready  s_tdata: stamps, s_tuser: tick, capture mask
//  m_        out   m_tvalid/m_tready  m_tdata: speeds, m_tuser: present, fresh
//  cfg_      in    cfg_we             cfg_addr, cfg_wdata
//
//  One word in, one word out. A speed takes a quotient from the shared
//  serial divider; a filter update takes a shift-add multiply, a gain index
//  divide and the control steps in ST_CAP and ST_FILT.
//  Reset is synchronous, active low; all channel state returns to no signal.
//  A result waits in the output register; the next word is accepted while
//  it waits, and the block only stalls at finish if it is still not taken.
// ----------------------------------------------------------------------------
`include "tachometer_adaptive_iir_unit_macros.svh"

module tachometer_adaptive_iir_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [25:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // stamp_ch0, stamp_ch1, stamp_ch2, stamp_ch3
    input  logic [4:0]   s_tuser,   // tick, capture_mask[3:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // speed_ch0..speed_ch3 (27b each), zero pad
    output logic [4:0]   m_tuser    // present_mask[3:0], speeds_fresh
);

    localparam int NCH = tai_pkg::CHANNELS;
    localparam logic [tai_pkg::CH_W-1:0] LAST_CH = tai_pkg::CH_W'(NCH - 1);

    // config registers
    logic [7:0]  timeout_reg;
    logic [25:0] scale_reg;
    logic [23:0] rise_reg;

    // channel state
    logic [31:0]                  cycle_reg;
    logic [31:0]                  last_cycle_reg [NCH];
    logic [15:0]                  last_stamp_reg [NCH];
    logic [tai_pkg::GAIN_W-1:0]   gain_reg       [NCH];
    logic signed [31:0]           filt_reg       [NCH];
    logic signed [tai_pkg::SPEED_W-1:0] speed_reg [NCH];

    // word being worked on
    logic                         tick_reg;
    logic [NCH-1:0]               mask_reg;
    logic [15:0]                  stamp_reg [NCH];
    logic [tai_pkg::CH_W-1:0]     ch_reg;

    // serial multiply
    logic signed [tai_pkg::PROD_W-1:0] mcand_reg;
    logic signed [tai_pkg::PROD_W-1:0] acc_reg;
    logic [tai_pkg::GAIN_W-1:0]        gsh_reg;
    logic [tai_pkg::CNT_W-1:0]         mul_cnt_reg;
    logic signed [31:0]                raw_reg;

    // output register
    logic         m_tvalid_reg;
    logic [111:0] m_tdata_reg;
    logic [4:0]   m_tuser_reg;
    logic [111:0] out_data;
    logic [4:0]   out_user;

    tai_pkg::state_t   state_reg, state_next;
    tai_pkg::div_req_t div_req;
    logic              div_busy, div_done;
    logic [tai_pkg::NUM_W-1:0] div_quot;

    logic               accept, adv, out_load, ch_last;
    logic signed [31:0] cur_filt;
    logic               cur_neg, cur_zero, cur_cap;
    logic [31:0]        raw_d;
    logic               raw_nonpos;
    logic signed [tai_pkg::PROD_W-1:0] prod_sh;
    logic signed [31:0] filt_new;
    logic [tai_pkg::IDX_W-1:0] gain_idx;
    logic [NCH-1:0]     gain_ok;

    assign accept   = s_tvalid && s_tready;
    assign ch_last  = ch_reg == LAST_CH;
    assign cur_filt = filt_reg[ch_reg];
    assign cur_neg  = cur_filt[31];
    assign cur_zero = cur_filt == '0;
    assign cur_cap  = mask_reg[ch_reg];

    // raw interval: stamp delta plus overflow delta, wraps at 32 bits
    assign raw_d = 32'(({16'd0, stamp_reg[ch_reg]} - {16'd0, last_stamp_reg[ch_reg]})
                 + ((cycle_reg - last_cycle_reg[ch_reg]) << tai_pkg::COUNTER_BITS));
    assign raw_nonpos = raw_reg[31] || (raw_reg == '0);

    // floor divide by 4096 is an arithmetic shift
    assign prod_sh  = acc_reg >>> tai_pkg::GAIN_SHIFT;
    assign filt_new = 32'(cur_filt + prod_sh[31:0]);

    assign gain_idx = (|div_quot[tai_pkg::NUM_W-1:tai_pkg::IDX_W])
                    ? tai_pkg::IDX_W'(tai_pkg::GAIN_ENTRIES - 1)
                    : div_quot[tai_pkg::IDX_W-1:0];

    tai_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tai_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser[0] ? tai_pkg::ST_SPD : tai_pkg::ST_CAP;
                end
            end
            tai_pkg::ST_SPD: begin
                if (!cur_neg && !cur_zero) begin
                    state_next = tai_pkg::ST_SPD_WAIT;
                end else if (ch_last) begin
                    state_next = tai_pkg::ST_CAP;
                end
            end
            tai_pkg::ST_SPD_WAIT: begin
                if (div_done) begin
                    state_next = ch_last ? tai_pkg::ST_CAP : tai_pkg::ST_SPD;
                end
            end
            tai_pkg::ST_CAP: begin
                if (cur_cap && !cur_neg) begin
                    state_next = tai_pkg::ST_MUL;
                end else if (ch_last) begin
                    state_next = tai_pkg::ST_TIMEOUT;
                end
            end
            tai_pkg::ST_MUL: begin
                if (mul_cnt_reg == tai_pkg::CNT_W'(tai_pkg::GAIN_W - 1)) begin
                    state_next = tai_pkg::ST_FILT;
                end
            end
            tai_pkg::ST_FILT: begin
                if (!raw_nonpos) begin
                    state_next = tai_pkg::ST_IDX_WAIT;
                end else begin
                    state_next = ch_last ? tai_pkg::ST_TIMEOUT : tai_pkg::ST_CAP;
                end
            end
            tai_pkg::ST_IDX_WAIT: begin
                if (div_done) begin
                    state_next = ch_last ? tai_pkg::ST_TIMEOUT : tai_pkg::ST_CAP;
                end
            end
            tai_pkg::ST_TIMEOUT: state_next = tai_pkg::ST_DONE;
            tai_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = tai_pkg::ST_IDLE;
                end
            end
            default: state_next = tai_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready      = 1'b0;
        adv           = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = scale_reg;
        div_req.den   = cur_filt;
        case (state_reg)
            tai_pkg::ST_IDLE: s_tready = 1'b1;
            tai_pkg::ST_SPD: begin
                div_req.start = !cur_neg && !cur_zero;
                adv           = cur_neg || cur_zero;
            end
            tai_pkg::ST_SPD_WAIT: adv = div_done;
            tai_pkg::ST_CAP:      adv = !(cur_cap && !cur_neg);
            tai_pkg::ST_FILT: begin
                div_req.num   = {2'd0, rise_reg};
                div_req.den   = raw_reg;
                div_req.start = !raw_nonpos;
                adv           = raw_nonpos;
            end
            tai_pkg::ST_IDX_WAIT: adv = div_done;
            tai_pkg::ST_DONE:     out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tai_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 8'd2;
            scale_reg   <= 26'd19636364;
            rise_reg    <= 24'd65455;
        end else if (cfg_we) begin
            case (cfg_addr)
                tai_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata[7:0];
                tai_pkg::REG_SCALE:   scale_reg   <= cfg_wdata;
                tai_pkg::REG_RISE:    rise_reg    <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_reg <= '0;
            for (int i = 0; i < NCH; i++) begin
                last_cycle_reg[i] <= '0;
                last_stamp_reg[i] <= '0;
                gain_reg[i]       <= '0;
                filt_reg[i]       <= -32'sd1;
                speed_reg[i]      <= -27'sd1;
            end
        end else begin
            case (state_reg)
                tai_pkg::ST_IDLE: begin
                    if (accept && s_tuser[0]) begin
                        cycle_reg <= cycle_reg + 32'd1;
                    end
                end
                tai_pkg::ST_SPD: begin
                    if (cur_neg) begin
                        speed_reg[ch_reg] <= -27'sd1;
                    end else if (cur_zero) begin
                        speed_reg[ch_reg] <= {1'b0, scale_reg};
                    end
                end
                tai_pkg::ST_SPD_WAIT: begin
                    if (div_done) begin
                        speed_reg[ch_reg] <= {1'b0, div_quot};
                    end
                end
                tai_pkg::ST_CAP: begin
                    if (cur_cap) begin
                        last_cycle_reg[ch_reg] <= cycle_reg;
                        last_stamp_reg[ch_reg] <= stamp_reg[ch_reg];
                        if (cur_neg) begin
                            // first capture: seed, full gain
                            filt_reg[ch_reg] <= {8'd0, timeout_reg, 16'd0};
                            gain_reg[ch_reg] <= tai_pkg::FULL_GAIN;
                        end
                    end
                end
                tai_pkg::ST_FILT: begin
                    filt_reg[ch_reg] <= filt_new;
                    if (raw_nonpos) begin
                        gain_reg[ch_reg] <= tai_pkg::GAIN_LUT[tai_pkg::GAIN_ENTRIES-1];
                    end
                end
                tai_pkg::ST_IDX_WAIT: begin
                    if (div_done) begin
                        gain_reg[ch_reg] <= tai_pkg::GAIN_LUT[gain_idx];
                    end
                end
                tai_pkg::ST_TIMEOUT: begin
                    for (int i = 0; i < NCH; i++) begin
                        if ((cycle_reg - last_cycle_reg[i]) > {24'd0, timeout_reg}) begin
                            filt_reg[i] <= -32'sd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // word latch, channel walk, multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= '0;
        end else if (accept) begin
            ch_reg <= '0;
        end else if (adv) begin
            ch_reg <= ch_last ? '0 : ch_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tick_reg <= s_tuser[0];
            mask_reg <= s_tuser[4:1];
            for (int i = 0; i < NCH; i++) begin
                stamp_reg[i] <= s_tdata[16*i +: 16];
            end
        end
        if (state_reg == tai_pkg::ST_CAP) begin
            raw_reg     <= raw_d;
            mcand_reg   <= tai_pkg::PROD_W'(signed'(raw_d)) - tai_pkg::PROD_W'(cur_filt);
            acc_reg     <= '0;
            gsh_reg     <= gain_reg[ch_reg];
            mul_cnt_reg <= '0;
        end else if (state_reg == tai_pkg::ST_MUL) begin
            if (gsh_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg   <= mcand_reg <<< 1;
            gsh_reg     <= gsh_reg >> 1;
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
        end
    end

    // result word assembly
    always_comb begin
        out_data = '0;
        out_user = '0;
        for (int i = 0; i < NCH; i++) begin
            out_data[tai_pkg::SPEED_W*i +: tai_pkg::SPEED_W] = speed_reg[i];
            out_user[i] = !filt_reg[i][31];
        end
        out_user[4] = tick_reg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            gain_ok[i] = gain_reg[i] <= tai_pkg::FULL_GAIN;
        end
    end

    `TAI_ASSERT_NOW(a_div_idle, aclk, aresetn, div_req.start, !div_busy, "divider restarted while busy")
    `TAI_ASSERT_NOW(a_mul_masked, aclk, aresetn, state_reg == tai_pkg::ST_MUL, cur_cap, "filter step on channel without capture")
    `TAI_ASSERT_NOW(a_gain_range, aclk, aresetn, 1'b1, &gain_ok, "filter gain above full scale")
    `TAI_ASSERT_NEXT(a_load_valid, aclk, aresetn, out_load, m_tvalid && state_reg == tai_pkg::ST_IDLE, "result not presented after finish")

endmodule
